/* rtl/apsp_pkg.sv */
// shared types and constants of the all-pairs shortest path engine
package apsp_pkg;

  localparam int unsigned NODE_W = 6;
  localparam int unsigned COST_W = 16;
  localparam int unsigned DIST_W = 32;
  localparam int unsigned CFG_W  = 7;

  localparam logic [CFG_W-1:0]  NODE_COUNT_RESET = 7'd64;
  localparam logic [DIST_W-1:0] DIST_INF = 32'hFFFF_FFFF;
  localparam logic [DIST_W-1:0] DIST_MAX = 32'hFFFF_FFFE;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_EDGE  = 2'd1;
  localparam logic [1:0] FUNC_RUN   = 2'd2;
  localparam logic [1:0] FUNC_QUERY = 2'd3;

  localparam logic KIND_RUN   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic [1:0]        func;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
    logic [COST_W-1:0] edge_cost;
  } cmd_t;

  typedef struct packed {
    logic              kind;
    logic [DIST_W-1:0] distance;
    logic              reachable;
  } res_t;

endpackage

/* rtl/apsp_ram.sv */
// generic single-write, single-read ram with registered read data
module apsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/all_pairs_shortest_paths.sv */
// top level of the all-pairs shortest path engine
// clear: writes every matrix word, one matrix word per cycle
// add edge: written in the cycle of the transaction
// query: matrix word read, then held in pend, then registered to res once the result slot is free
// run: over the n nodes in use, reads go one at a time through the one read port of the matrix ram
// one command at a time; a waiting result does not stop the next command being taken
// reset (synchronous, active high) clears control, node_count to 64; matrix undefined till cleared
module all_pairs_shortest_paths
  import apsp_pkg::*;
#(
  parameter int MAX_NODES = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  cmd_t             cmd,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int IW    = $clog2(MAX_NODES);
  localparam int NW    = $clog2(MAX_NODES + 1);
  localparam int AW    = 2 * IW;
  localparam int DEPTH = 1 << AW;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_CLR     = 9'b000000010,
    S_RUN_IK  = 9'b000000100,
    S_RUN_IKD = 9'b000001000,
    S_RUN_KJ  = 9'b000010000,
    S_RUN_KJD = 9'b000100000,
    S_RUN_UPD = 9'b001000000,
    S_QRY     = 9'b010000000,
    S_FIN     = 9'b100000000
  } state_t;

  state_t            state;
  logic [CFG_W-1:0]  node_count;
  logic [IW-1:0]     k, i, j;
  logic [AW-1:0]     clr_addr;
  logic [DIST_W-1:0] dik, dkj;
  logic              q_ok;
  res_t              pend;

  logic [NW-1:0]     n_eff;
  logic [IW-1:0]     n_last;
  logic              cmd_acc, slot_free, nodes_ok;
  logic              i_last, j_last, k_last;
  logic [IW-1:0]     i_adv, k_adv;
  state_t            st_adv;
  logic [DIST_W:0]   sum;
  logic [DIST_W-1:0] cand, q_dist;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [DIST_W-1:0] wdata, rdata;

  apsp_ram #(
    .WIDTH(DIST_W),
    .DEPTH(DEPTH)
  ) u_matrix (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // nodes in use, clamped to one .. MAX_NODES
  always_comb begin
    if (node_count == '0) begin
      n_eff = NW'(1);
    end else if (node_count > MAX_NODES) begin
      n_eff = NW'(MAX_NODES);
    end else begin
      n_eff = NW'(node_count);
    end
  end

  assign n_last    = IW'(n_eff - 1'b1);
  assign cmd_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign cmd_acc   = cmd_valid && cmd_ready;
  assign slot_free = !res_valid || res_ready;
  assign nodes_ok  = (cmd.from_node < n_eff) && (cmd.to_node < n_eff);

  assign i_last = (i == n_last);
  assign j_last = (j == n_last);
  assign k_last = (k == n_last);

  // where the walk goes once row i of pass k is finished
  always_comb begin
    if (i_last) begin
      i_adv  = '0;
      k_adv  = k + 1'b1;
      st_adv = k_last ? S_FIN : S_RUN_IK;
    end else begin
      i_adv  = i + 1'b1;
      k_adv  = k;
      st_adv = S_RUN_IK;
    end
  end

  // relaxed candidate, both terms finite
  assign sum  = {1'b0, dik} + {1'b0, dkj};
  assign cand = (sum > {1'b0, DIST_MAX}) ? DIST_MAX : sum[DIST_W-1:0];

  assign q_dist = q_ok ? rdata : DIST_INF;

  always_comb begin
    we    = 1'b0;
    waddr = {i, j};
    wdata = cand;
    raddr = {IW'(cmd.from_node), IW'(cmd.to_node)};
    case (state)
      S_IDLE: begin
        we    = cmd_acc && (cmd.func == FUNC_EDGE) && nodes_ok;
        waddr = {IW'(cmd.from_node), IW'(cmd.to_node)};
        wdata = {{(DIST_W - COST_W){1'b0}}, cmd.edge_cost};
      end
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = (clr_addr[AW-1:IW] == clr_addr[IW-1:0]) ? '0 : DIST_INF;
      end
      S_RUN_IK:  raddr = {i, k};
      S_RUN_KJ:  raddr = {k, j};
      S_RUN_KJD: raddr = {i, j};
      S_RUN_UPD: we    = (cand < rdata);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_valid  <= 1'b0;
      node_count <= NODE_COUNT_RESET;
      k          <= '0;
      i          <= '0;
      j          <= '0;
      clr_addr   <= '0;
    end else begin
      if (cfg_valid) begin
        node_count <= cfg_data;
      end
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_acc) begin
            case (cmd.func)
              FUNC_CLEAR: begin
                clr_addr <= '0;
                state    <= S_CLR;
              end
              FUNC_RUN: begin
                k     <= '0;
                i     <= '0;
                pend  <= '{kind: KIND_RUN, distance: '0, reachable: 1'b0};
                state <= S_RUN_IK;
              end
              FUNC_QUERY: begin
                q_ok  <= nodes_ok;
                state <= S_QRY;
              end
              default: ;
            endcase
          end
        end
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_RUN_IK: state <= S_RUN_IKD;
        S_RUN_IKD: begin
          dik <= rdata;
          if (rdata == DIST_INF) begin
            i     <= i_adv;
            k     <= k_adv;
            state <= st_adv;
          end else begin
            j     <= '0;
            state <= S_RUN_KJ;
          end
        end
        S_RUN_KJ: state <= S_RUN_KJD;
        S_RUN_KJD: begin
          dkj <= rdata;
          if (rdata != DIST_INF) begin
            state <= S_RUN_UPD;
          end else if (j_last) begin
            i     <= i_adv;
            k     <= k_adv;
            state <= st_adv;
          end else begin
            j     <= j + 1'b1;
            state <= S_RUN_KJ;
          end
        end
        S_RUN_UPD: begin
          if (j_last) begin
            i     <= i_adv;
            k     <= k_adv;
            state <= st_adv;
          end else begin
            j     <= j + 1'b1;
            state <= S_RUN_KJ;
          end
        end
        S_QRY: begin
          pend.kind      <= KIND_QUERY;
          pend.reachable <= (q_dist != DIST_INF);
          pend.distance  <= (q_dist != DIST_INF) ? q_dist : '0;
          state          <= S_FIN;
        end
        S_FIN: begin
          if (slot_free) begin
            res       <= pend;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

/* rtl/apsp_checker.sv */
// port-level checker for the shortest path engine, bound to the top level
module apsp_checker
  import apsp_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_ready,
  input cmd_t cmd,
  input logic res_valid,
  input logic res_ready,
  input res_t res
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result changed or dropped while stalled");

  // run and query occupy the engine
  a_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (cmd.func == FUNC_RUN || cmd.func == FUNC_QUERY)
    |=> !cmd_ready)
    else $error("engine took a command while still busy");

  // run acknowledgement carries no distance
  a_run_ack: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == KIND_RUN |-> res.distance == '0 && !res.reachable)
    else $error("run acknowledgement with payload");

  // unreachable answers zero, reachable never infinity
  a_reach: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == KIND_QUERY
    |-> (res.reachable ? res.distance != DIST_INF : res.distance == '0))
    else $error("query answer inconsistent with reachable flag");

  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind all_pairs_shortest_paths apsp_checker u_apsp_checker (.*);
